>>> rtl/fpwq_pkg.sv
// Package for the wait queue: sizes, command and status codes, shared types
// and the ring address helper. Used by fpwq_ctrl and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fpwq_pkg;

   // Store and field sizes.
   localparam int DEPTH       = 16;
   localparam int TASK_BITS   = 6;
   localparam int PRIO_BITS   = 8;
   localparam int CMD_BITS    = 2;
   localparam int WAKE_BITS   = 5;
   localparam int STATUS_BITS = 3;
   localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int CMP_BITS    = (WAKE_BITS > CNT_BITS) ? WAKE_BITS : CNT_BITS;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_TIMEOUT = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_WAKE    = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STAT_ENQUEUED = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_TIMEDOUT = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_WOKEN    = 3'd4;
   localparam logic [STATUS_BITS-1:0] STAT_EMPTY    = 3'd5;

   // One stored entry.
   typedef struct packed {
      logic [TASK_BITS-1:0] task_id;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // One result transaction toward the output register.
   typedef struct packed {
      logic                   valid;
      logic [STATUS_BITS-1:0] status;
      logic [TASK_BITS-1:0]   task_id;
      logic                   last;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_READ,
      S_INS_USE,
      S_DEL_READ,
      S_DEL_USE,
      S_WAKE_READ,
      S_WAKE_USE
   } state_type;

   // Physical slot of a logical position counted from the ring head.
   function automatic logic [IDX_BITS-1:0] phys_addr(input logic [IDX_BITS-1:0] head,
                                                     input logic [CNT_BITS-1:0] offset);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS + 1)'(head) + (CNT_BITS + 1)'(offset);
      if (sum >= (CNT_BITS + 1)'(DEPTH)) begin
         sum = sum - (CNT_BITS + 1)'(DEPTH);
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/fpwq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module fpwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/fpwq_ctrl.sv
// Sequencer of the wait queue: walks the ring store one entry at a time for
// insert, remove and wake, comparing entries against the key for insert and remove.
// Depends on fpwq_pkg and fpwq_ram.
`timescale 1ns / 1ps
`default_nettype none

module fpwq_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             queue_mode,
   input  wire logic [fpwq_pkg::CMD_BITS-1:0]    cmd,
   input  wire logic [fpwq_pkg::TASK_BITS-1:0]   task_id,
   input  wire logic [fpwq_pkg::PRIO_BITS-1:0]   prio,
   input  wire logic [fpwq_pkg::WAKE_BITS-1:0]   wake_count,
   output      logic                             busy,
   output      fpwq_pkg::rsp_type                rsp
);

   fpwq_pkg::state_type                 state_ff, state_in;
   logic [fpwq_pkg::IDX_BITS-1:0]       head_ff, head_in;
   logic [fpwq_pkg::CNT_BITS-1:0]       count_ff, count_in;
   logic [fpwq_pkg::CNT_BITS-1:0]       idx_ff, idx_in;
   logic [fpwq_pkg::CNT_BITS-1:0]       remain_ff, remain_in;
   logic                                found_ff, found_in;
   fpwq_pkg::entry_type                 carry_ff, carry_in;
   fpwq_pkg::entry_type                 key_ff, key_in;

   logic                                wr_en;
   logic [fpwq_pkg::IDX_BITS-1:0]       wr_addr;
   fpwq_pkg::entry_type                 wr_data;
   logic [fpwq_pkg::IDX_BITS-1:0]       rd_addr;
   logic [fpwq_pkg::ENTRY_BITS-1:0]     rd_bits;
   fpwq_pkg::entry_type                 rd_entry;
   logic                                accept;
   logic [fpwq_pkg::CMP_BITS-1:0]       want_ext;
   logic [fpwq_pkg::CMP_BITS-1:0]       count_ext;
   logic [fpwq_pkg::CNT_BITS-1:0]       wake_total;

   fpwq_ram #(
      .WIDTH (fpwq_pkg::ENTRY_BITS),
      .DEPTH (fpwq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry = rd_bits;
   assign busy     = (state_ff != fpwq_pkg::S_IDLE);
   assign accept   = start && !busy;

   // Number of tasks a wake removes: the request, capped by the fill level; zero wakes all.
   assign want_ext   = fpwq_pkg::CMP_BITS'(wake_count);
   assign count_ext  = fpwq_pkg::CMP_BITS'(count_ff);
   assign wake_total = ((wake_count != '0) && (want_ext < count_ext))
                       ? fpwq_pkg::CNT_BITS'(wake_count) : count_ff;

   // State and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpwq_pkg::S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      remain_ff <= remain_in;
      found_ff  <= found_in;
      carry_ff  <= carry_in;
      key_ff    <= key_in;
   end

   // Next state, store access and result generation.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      remain_in = remain_ff;
      found_in  = found_ff;
      carry_in  = carry_ff;
      key_in    = key_ff;
      wr_en     = 1'b0;
      wr_addr   = fpwq_pkg::phys_addr(head_ff, idx_ff);
      wr_data   = key_ff;
      rd_addr   = fpwq_pkg::phys_addr(head_ff, idx_ff);
      rsp       = '0;

      case (state_ff)
         fpwq_pkg::S_IDLE: begin
            if (accept) begin
               key_in.task_id = task_id;
               key_in.prio    = prio;
               idx_in         = '0;
               found_in       = 1'b0;
               case (cmd)
                  fpwq_pkg::CMD_ENQUEUE: begin
                     if (count_ff == fpwq_pkg::CNT_BITS'(fpwq_pkg::DEPTH)) begin
                        rsp.valid   = 1'b1;
                        rsp.status  = fpwq_pkg::STAT_FULL;
                        rsp.task_id = task_id;
                        rsp.last    = 1'b1;
                     end else begin
                        // FIFO order goes straight to the tail.
                        idx_in   = queue_mode ? '0 : count_ff;
                        state_in = fpwq_pkg::S_INS_READ;
                     end
                  end
                  fpwq_pkg::CMD_TIMEOUT: begin
                     state_in = fpwq_pkg::S_DEL_READ;
                  end
                  fpwq_pkg::CMD_WAKE: begin
                     if (count_ff == '0) begin
                        rsp.valid  = 1'b1;
                        rsp.status = fpwq_pkg::STAT_EMPTY;
                        rsp.last   = 1'b1;
                     end else begin
                        remain_in = wake_total;
                        state_in  = fpwq_pkg::S_WAKE_READ;
                     end
                  end
                  default: begin
                     // The unused command code is dropped without a result.
                  end
               endcase
            end
         end

         fpwq_pkg::S_INS_READ: begin
            // At the tail the new entry or the carried entry lands.
            if (idx_ff == count_ff) begin
               wr_en       = 1'b1;
               wr_data     = found_ff ? carry_ff : key_ff;
               count_in    = count_ff + 1'b1;
               rsp.valid   = 1'b1;
               rsp.status  = fpwq_pkg::STAT_ENQUEUED;
               rsp.task_id = key_ff.task_id;
               rsp.last    = 1'b1;
               state_in    = fpwq_pkg::S_IDLE;
            end else begin
               state_in = fpwq_pkg::S_INS_USE;
            end
         end

         fpwq_pkg::S_INS_USE: begin
            // Find the insert point, then ripple the entries behind it one slot toward the tail.
            if (found_ff) begin
               wr_en    = 1'b1;
               wr_data  = carry_ff;
               carry_in = rd_entry;
            end else if (rd_entry.prio > key_ff.prio) begin
               wr_en    = 1'b1;
               wr_data  = key_ff;
               carry_in = rd_entry;
               found_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = fpwq_pkg::S_INS_READ;
         end

         fpwq_pkg::S_DEL_READ: begin
            if (idx_ff == count_ff) begin
               rsp.valid   = 1'b1;
               rsp.status  = found_ff ? fpwq_pkg::STAT_TIMEDOUT : fpwq_pkg::STAT_NOTFOUND;
               rsp.task_id = key_ff.task_id;
               rsp.last    = 1'b1;
               if (found_ff) begin
                  count_in = count_ff - 1'b1;
               end
               state_in = fpwq_pkg::S_IDLE;
            end else begin
               state_in = fpwq_pkg::S_DEL_USE;
            end
         end

         fpwq_pkg::S_DEL_USE: begin
            // After the match every entry moves one slot toward the head.
            wr_addr = fpwq_pkg::phys_addr(head_ff, idx_ff - 1'b1);
            wr_data = rd_entry;
            if (found_ff) begin
               wr_en = 1'b1;
            end else if (rd_entry.task_id == key_ff.task_id) begin
               found_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = fpwq_pkg::S_DEL_READ;
         end

         fpwq_pkg::S_WAKE_READ: begin
            rd_addr  = head_ff;
            state_in = fpwq_pkg::S_WAKE_USE;
         end

         fpwq_pkg::S_WAKE_USE: begin
            // Pop the head entry and report it.
            rsp.valid   = 1'b1;
            rsp.status  = fpwq_pkg::STAT_WOKEN;
            rsp.task_id = rd_entry.task_id;
            rsp.last    = (remain_ff == fpwq_pkg::CNT_BITS'(1));
            head_in     = fpwq_pkg::phys_addr(head_ff, fpwq_pkg::CNT_BITS'(1));
            count_in    = count_ff - 1'b1;
            remain_in   = remain_ff - 1'b1;
            state_in    = (remain_ff == fpwq_pkg::CNT_BITS'(1))
                          ? fpwq_pkg::S_IDLE : fpwq_pkg::S_WAKE_READ;
         end

         default: begin
            state_in = fpwq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/fifo_or_priority_wait_queue.sv
// Top level of the wait queue: mode register, sequencer and result register.
// Depends on fpwq_pkg and fpwq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Wait queue of up to DEPTH task ids in FIFO or stable priority order. A
// command is taken when start is high and busy is low; its results appear on
// the rsp_ ports, each flagged by rsp_strobe for one cycle, and the receiver
// cannot stall them. The store is a ring in a single-port-read RAM with
// registered read data, walked one entry at a time. A full enqueue and an
// empty wake answer at once and leave busy low; the unused command gives no
// result and leaves busy low. The queue_mode register is written through the
// csr_ channel; the user must write it only while idle, as the block itself
// does not enforce this.
module fifo_or_priority_wait_queue (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output      logic                             busy,
   input  wire logic [fpwq_pkg::CMD_BITS-1:0]    req_cmd,
   input  wire logic [fpwq_pkg::TASK_BITS-1:0]   req_task_id,
   input  wire logic [fpwq_pkg::PRIO_BITS-1:0]   req_priority_req,
   input  wire logic [fpwq_pkg::WAKE_BITS-1:0]   req_wake_count,
   output      logic                             rsp_strobe,
   output      logic [fpwq_pkg::STATUS_BITS-1:0] rsp_status,
   output      logic [fpwq_pkg::TASK_BITS-1:0]   rsp_out_task,
   output      logic                             rsp_last,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic                             csr_queue_mode
);

   logic              mode_ff;
   fpwq_pkg::rsp_type rsp_in;
   fpwq_pkg::rsp_type rsp_ff;

   // The mode register takes every write transaction at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_queue_mode;
      end
   end

   fpwq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .queue_mode (mode_ff),
      .cmd        (req_cmd),
      .task_id    (req_task_id),
      .prio       (req_priority_req),
      .wake_count (req_wake_count),
      .busy       (busy),
      .rsp        (rsp_in)
   );

   // Result register: each result transaction is shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.status  <= rsp_in.status;
      rsp_ff.task_id <= rsp_in.task_id;
      rsp_ff.last    <= rsp_in.last;
   end

   assign rsp_strobe   = rsp_ff.valid;
   assign rsp_status   = rsp_ff.status;
   assign rsp_out_task = rsp_ff.task_id;
   assign rsp_last     = rsp_ff.last;

endmodule

`default_nettype wire

>>> tb/sv/tb_fifo_or_priority_wait_queue.sv
// Self-checking testbench for the wait queue: a directed table followed by random phases,
// checked transaction by transaction against a behavioral model of the queue.
// Depends on fpwq_pkg and fifo_or_priority_wait_queue.
`timescale 1ns / 1ps

module tb_fifo_or_priority_wait_queue;

   localparam logic [fpwq_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS   = 440;
   localparam int PHASE_ITEMS    = 80;
   localparam int SETTLE_CYCLES  = 2 * fpwq_pkg::DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // One result transaction as the checker sees it.
   typedef struct packed {
      logic [fpwq_pkg::STATUS_BITS-1:0] status;
      logic [fpwq_pkg::TASK_BITS-1:0]   task_id;
      logic                             last;
   } queue_result_type;

   // One row of the directed table: a command, or a write of the mode register.
   typedef struct {
      bit                               is_cfg;
      bit                               mode;
      logic [fpwq_pkg::CMD_BITS-1:0]    cmd;
      logic [fpwq_pkg::TASK_BITS-1:0]   task_id;
      logic [fpwq_pkg::PRIO_BITS-1:0]   prio;
      logic [fpwq_pkg::WAKE_BITS-1:0]   wake;
      int                               reps;
      bit                               typed;
      logic [fpwq_pkg::STATUS_BITS-1:0] exp_status;
      logic [fpwq_pkg::TASK_BITS-1:0]   exp_task;
   } dir_row_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [fpwq_pkg::CMD_BITS-1:0]    req_cmd;
   logic [fpwq_pkg::TASK_BITS-1:0]   req_task_id;
   logic [fpwq_pkg::PRIO_BITS-1:0]   req_priority_req;
   logic [fpwq_pkg::WAKE_BITS-1:0]   req_wake_count;
   logic                             rsp_strobe;
   logic [fpwq_pkg::STATUS_BITS-1:0] rsp_status;
   logic [fpwq_pkg::TASK_BITS-1:0]   rsp_out_task;
   logic                             rsp_last;
   logic                             csr_valid;
   logic                             csr_ready;
   logic                             csr_queue_mode;

   // Typed expectation that goes along with the command on the request ports.
   bit                               cur_typed;
   logic [fpwq_pkg::STATUS_BITS-1:0] cur_exp_status;
   logic [fpwq_pkg::TASK_BITS-1:0]   cur_exp_task;

   // Behavioral copy of the queue contents and the mode register.
   logic [fpwq_pkg::TASK_BITS-1:0]   wq_task [fpwq_pkg::DEPTH];
   logic [fpwq_pkg::PRIO_BITS-1:0]   wq_prio [fpwq_pkg::DEPTH];
   int                               model_count;
   bit                               wq_mode;

   queue_result_type                 expected_results [$];
   dir_row_type                      dir_table [$];
   int                               fail_count;
   int                               stall_cycles;
   bit                               no_idle;

   fifo_or_priority_wait_queue u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .req_wake_count   (req_wake_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_task     (rsp_out_task),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_queue_mode   (csr_queue_mode)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count a failure; only the first few are described.
   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   task automatic push_result(input bit record,
                              input logic [fpwq_pkg::STATUS_BITS-1:0] status,
                              input logic [fpwq_pkg::TASK_BITS-1:0] task_id,
                              input logic last);
      if (record) begin
         expected_results.push_back('{status, task_id, last});
      end
   endtask

   // Close the gap left by the entry at pos.
   task automatic remove_entry(input int pos);
      for (int i = pos; i + 1 < model_count; i++) begin
         wq_task[i] = wq_task[i + 1];
         wq_prio[i] = wq_prio[i + 1];
      end
      model_count--;
   endtask

   // Apply one accepted command to the model and queue the results it causes.
   task automatic predict_queue_op(input logic [fpwq_pkg::CMD_BITS-1:0] cmd,
                                   input logic [fpwq_pkg::TASK_BITS-1:0] task_id,
                                   input logic [fpwq_pkg::PRIO_BITS-1:0] prio,
                                   input logic [fpwq_pkg::WAKE_BITS-1:0] wake,
                                   input bit record);
      int pos;
      int n;
      bit found;
      logic [fpwq_pkg::TASK_BITS-1:0] woken;
      case (cmd)
         fpwq_pkg::CMD_ENQUEUE: begin
            if (model_count >= fpwq_pkg::DEPTH) begin
               push_result(record, fpwq_pkg::STAT_FULL, task_id, 1'b1);
            end else begin
               pos = model_count;
               if (wq_mode) begin
                  for (int i = model_count - 1; i >= 0; i--) begin
                     if (wq_prio[i] > prio) begin
                        pos = i;
                     end
                  end
               end
               for (int i = model_count; i > pos; i--) begin
                  wq_task[i] = wq_task[i - 1];
                  wq_prio[i] = wq_prio[i - 1];
               end
               wq_task[pos] = task_id;
               wq_prio[pos] = prio;
               model_count++;
               push_result(record, fpwq_pkg::STAT_ENQUEUED, task_id, 1'b1);
            end
         end
         fpwq_pkg::CMD_TIMEOUT: begin
            found = 1'b0;
            for (int i = 0; i < model_count && !found; i++) begin
               if (wq_task[i] == task_id) begin
                  remove_entry(i);
                  found = 1'b1;
               end
            end
            push_result(record, found ? fpwq_pkg::STAT_TIMEDOUT : fpwq_pkg::STAT_NOTFOUND,
                        task_id, 1'b1);
         end
         fpwq_pkg::CMD_WAKE: begin
            if (model_count == 0) begin
               push_result(record, fpwq_pkg::STAT_EMPTY, '0, 1'b1);
            end else begin
               n = model_count;
               if (wake != 0 && int'(wake) < n) begin
                  n = int'(wake);
               end
               for (int k = 0; k < n; k++) begin
                  woken = wq_task[0];
                  remove_entry(0);
                  push_result(record, fpwq_pkg::STAT_WOKEN, woken, (k == n - 1));
               end
            end
         end
         default: begin
            // The unused command changes nothing and answers nothing.
         end
      endcase
   endtask

   // Sample accepted transactions, keep the model in step and check every result.
   always @(posedge clock) begin
      bit active;
      queue_result_type want;
      active = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            active = 1'b1;
            if (cur_typed) begin
               predict_queue_op(req_cmd, req_task_id, req_priority_req, req_wake_count, 1'b0);
               expected_results.push_back('{cur_exp_status, cur_exp_task, 1'b1});
            end else begin
               predict_queue_op(req_cmd, req_task_id, req_priority_req, req_wake_count, 1'b1);
            end
         end
         if (csr_valid && csr_ready) begin
            active = 1'b1;
            wq_mode = csr_queue_mode;
         end
         if (rsp_strobe) begin
            active = 1'b1;
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result: status %0d task %0d last %0d",
                                      rsp_status, rsp_out_task, rsp_last));
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status || rsp_out_task !== want.task_id ||
                   rsp_last !== want.last) begin
                  note_failure($sformatf(
                     "mismatch: expected status %0d task %0d last %0d, got %0d %0d %0d",
                     want.status, want.task_id, want.last,
                     rsp_status, rsp_out_task, rsp_last));
               end
            end
         end
         // Watchdog on cycles without any transaction.
         if (active) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("tb_fifo_or_priority_wait_queue: FAIL");
            $finish;
         end
      end
   end

   // Gap after a command: mostly none or short, now and then long; always none under no_idle.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Drive one command and hold it until the block takes it.
   task automatic issue_command(input logic [fpwq_pkg::CMD_BITS-1:0] cmd,
                                input logic [fpwq_pkg::TASK_BITS-1:0] task_id,
                                input logic [fpwq_pkg::PRIO_BITS-1:0] prio,
                                input logic [fpwq_pkg::WAKE_BITS-1:0] wake,
                                input bit typed,
                                input logic [fpwq_pkg::STATUS_BITS-1:0] exp_status,
                                input logic [fpwq_pkg::TASK_BITS-1:0] exp_task);
      @(negedge clock);
      req_cmd          = cmd;
      req_task_id      = task_id;
      req_priority_req = prio;
      req_wake_count   = wake;
      cur_typed        = typed;
      cur_exp_status   = exp_status;
      cur_exp_task     = exp_task;
      start            = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Let the block drain, then write the mode register.
   task automatic write_mode(input bit mode);
      @(negedge clock);
      start = 1'b0;
      while (expected_results.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid      = 1'b1;
      csr_queue_mode = mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic dir_row_type cmd_row(input logic [fpwq_pkg::CMD_BITS-1:0] cmd,
                                           input int task_id, input int prio,
                                           input int wake, input int reps);
      dir_row_type r;
      r = '{default: 0};
      r.cmd = cmd;
      r.task_id = fpwq_pkg::TASK_BITS'(task_id);
      r.prio = fpwq_pkg::PRIO_BITS'(prio);
      r.wake = fpwq_pkg::WAKE_BITS'(wake);
      r.reps = reps;
      return r;
   endfunction

   function automatic dir_row_type typed_row(input logic [fpwq_pkg::CMD_BITS-1:0] cmd,
                                             input int task_id, input int prio,
                                             input int wake,
                                             input logic [fpwq_pkg::STATUS_BITS-1:0] status,
                                             input int exp_task);
      dir_row_type r;
      r = cmd_row(cmd, task_id, prio, wake, 1);
      r.typed = 1'b1;
      r.exp_status = status;
      r.exp_task = fpwq_pkg::TASK_BITS'(exp_task);
      return r;
   endfunction

   function automatic dir_row_type cfg_row(input bit mode);
      dir_row_type r;
      r = '{default: 0};
      r.is_cfg = 1'b1;
      r.mode = mode;
      return r;
   endfunction

   initial begin
      int random_items;
      int phase;
      int phase_items;
      int enq_pct;
      int roll;
      logic [fpwq_pkg::CMD_BITS-1:0]  cmd;
      logic [fpwq_pkg::TASK_BITS-1:0] task_id;
      logic [fpwq_pkg::PRIO_BITS-1:0] prio;
      logic [fpwq_pkg::WAKE_BITS-1:0] wake;

      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = fpwq_pkg::CMD_ENQUEUE;
      req_task_id      = '0;
      req_priority_req = '0;
      req_wake_count   = '0;
      csr_valid        = 1'b0;
      csr_queue_mode   = 1'b0;
      cur_typed        = 1'b0;
      cur_exp_status   = fpwq_pkg::STAT_ENQUEUED;
      cur_exp_task     = '0;
      model_count      = 0;
      wq_mode          = 1'b0;
      fail_count       = 0;
      stall_cycles     = 0;
      no_idle          = 1'b0;
      random_items     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: empty and absent cases, extremes, duplicates, ties and a full store.
      dir_table.push_back(typed_row(fpwq_pkg::CMD_WAKE, 0, 0, 0, fpwq_pkg::STAT_EMPTY, 0));
      dir_table.push_back(typed_row(fpwq_pkg::CMD_TIMEOUT, 63, 0, 0,
                                    fpwq_pkg::STAT_NOTFOUND, 63));
      dir_table.push_back(typed_row(fpwq_pkg::CMD_ENQUEUE, 0, 255, 0,
                                    fpwq_pkg::STAT_ENQUEUED, 0));
      dir_table.push_back(typed_row(fpwq_pkg::CMD_ENQUEUE, 63, 0, 0,
                                    fpwq_pkg::STAT_ENQUEUED, 63));
      dir_table.push_back(typed_row(fpwq_pkg::CMD_ENQUEUE, 63, 0, 0,
                                    fpwq_pkg::STAT_ENQUEUED, 63));
      dir_table.push_back(typed_row(fpwq_pkg::CMD_TIMEOUT, 63, 0, 0,
                                    fpwq_pkg::STAT_TIMEDOUT, 63));
      dir_table.push_back(cmd_row(CMD_UNUSED, 21, 170, 10, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_WAKE, 0, 0, 16, 1));
      dir_table.push_back(cfg_row(1'b1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_ENQUEUE, 5, 10, 0, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_ENQUEUE, 6, 10, 0, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_ENQUEUE, 7, 0, 0, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_ENQUEUE, 8, 255, 0, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_ENQUEUE, 9, 10, 0, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_WAKE, 0, 0, 1, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_WAKE, 0, 0, 0, 1));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_ENQUEUE, 42, 128, 0, fpwq_pkg::DEPTH));
      dir_table.push_back(typed_row(fpwq_pkg::CMD_ENQUEUE, 17, 0, 0,
                                    fpwq_pkg::STAT_FULL, 17));
      dir_table.push_back(typed_row(fpwq_pkg::CMD_TIMEOUT, 42, 0, 0,
                                    fpwq_pkg::STAT_TIMEDOUT, 42));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_WAKE, 0, 0, 16, 1));
      dir_table.push_back(cfg_row(1'b0));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_ENQUEUE, 1, 200, 0, 2));
      dir_table.push_back(cmd_row(fpwq_pkg::CMD_WAKE, 0, 0, 3, 1));

      foreach (dir_table[r]) begin
         if (dir_table[r].is_cfg) begin
            write_mode(dir_table[r].mode);
         end else begin
            repeat (dir_table[r].reps) begin
               issue_command(dir_table[r].cmd, dir_table[r].task_id, dir_table[r].prio,
                             dir_table[r].wake, dir_table[r].typed,
                             dir_table[r].exp_status, dir_table[r].exp_task);
               idle_cycles(pick_gap());
            end
         end
      end

      // Random phases, each under its own mode and command mix.
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase == 0) begin
            write_mode(1'b1);
         end else if (phase == 1) begin
            write_mode(1'b0);
         end else begin
            write_mode(1'($urandom_range(0, 1)));
         end
         no_idle     = (phase == 2) || ($urandom_range(0, 4) == 0);
         enq_pct     = $urandom_range(40, 75);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            task_id = fpwq_pkg::TASK_BITS'(($urandom_range(0, 1) == 0) ?
                                           $urandom_range(0, 7) : $urandom_range(0, 63));
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
               prio = fpwq_pkg::PRIO_BITS'($urandom_range(0, 3));
            end else if (roll == 4) begin
               prio = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            end else begin
               prio = fpwq_pkg::PRIO_BITS'($urandom_range(0, 255));
            end
            roll = $urandom_range(0, 19);
            if (roll < 6) begin
               wake = fpwq_pkg::WAKE_BITS'($urandom_range(1, 3));
            end else if (roll < 9) begin
               wake = '0;
            end else if (roll < 11) begin
               wake = fpwq_pkg::WAKE_BITS'(16);
            end else begin
               wake = fpwq_pkg::WAKE_BITS'($urandom_range(0, 16));
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               cmd = CMD_UNUSED;
            end else if (roll < 3 + enq_pct) begin
               cmd = fpwq_pkg::CMD_ENQUEUE;
            end else if (roll < 3 + enq_pct + (97 - enq_pct) / 2) begin
               cmd = fpwq_pkg::CMD_TIMEOUT;
               // Mostly name a task that is actually waiting.
               if (model_count > 0 && $urandom_range(0, 9) < 7) begin
                  task_id = wq_task[$urandom_range(0, model_count - 1)];
               end
            end else begin
               cmd = fpwq_pkg::CMD_WAKE;
            end
            issue_command(cmd, task_id, prio, wake, 1'b0, fpwq_pkg::STAT_ENQUEUED, '0);
            if (cmd != CMD_UNUSED) begin
               random_items++;
               phase_items++;
            end
            idle_cycles(pick_gap());
         end
         phase++;
      end

      // Drain and let the block settle before the verdict.
      @(negedge clock);
      start = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", expected_results.size()));
      end
      if (fail_count == 0) begin
         $display("tb_fifo_or_priority_wait_queue: PASS");
      end else begin
         $display("tb_fifo_or_priority_wait_queue: FAIL");
      end
      $finish;
   end

endmodule
